// File: sv/cccrc_pkg.sv
`timescale 1ns / 1ps

package cccrc_pkg;

  // check modes, codes 6 and 7 fall back to the byte sum
  typedef enum logic [2:0] {
    MODE_SUM8    = 3'd0,
    MODE_SUM16W  = 3'd1,
    MODE_CRC8    = 3'd2,
    MODE_CRC16   = 3'd3,
    MODE_CRC32   = 3'd4,
    MODE_SUM16B  = 3'd5
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_BIG_ENDIAN = 3'd1;
  localparam logic [2:0] REG_POLY       = 3'd2;
  localparam logic [2:0] REG_SEED       = 3'd3;
  localparam logic [2:0] REG_CRC_XOR    = 3'd4;
  localparam logic [2:0] REG_CRC_REFL   = 3'd5;

  localparam logic [31:0] POLY_RESET = 32'h0000_0007;

  // configuration seen by the datapath
  typedef struct packed {
    mode_t       mode;
    logic        big_endian;
    logic [31:0] poly_word;
    logic [31:0] seed_word;
    logic [31:0] crc_xor_out;
    logic        crc_reflect;
  } cfg_t;

  // running state carried between bytes
  typedef struct packed {
    logic [31:0] acc;
    logic [7:0]  held_byte;
    logic        byte_pending;
    logic        range_open;
  } state_t;

endpackage

// File: sv/cccrc_datapath.sv
`timescale 1ns / 1ps

module cccrc_datapath (
  input  cccrc_pkg::cfg_t   cfg,
  input  cccrc_pkg::state_t st,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output cccrc_pkg::state_t st_nxt,
  output logic [31:0]       check_value
);

  // bit reversal of a full word
  function automatic logic [31:0] rev32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31 - i];
    end
    return r;
  endfunction

  logic [4:0]  sh;
  logic [31:0] mask;
  logic        is_crc;
  logic [31:0] init_m;
  logic [31:0] poly_m;
  logic [31:0] start_val;
  logic [31:0] acc0;
  logic [7:0]  held0;
  logic        pend0;
  logic [31:0] c_norm;
  logic [31:0] p_al;
  logic [31:0] c_refl;
  logic [31:0] rp;
  logic [31:0] crc_n;
  logic [31:0] acc1;
  logic [7:0]  held1;
  logic        pend1;
  logic [15:0] pair_w;
  logic [15:0] tail_w;
  logic [15:0] word_sum;

  // crc width as an alignment shift and a mask
  always_comb begin
    is_crc = 1'b1;
    case (cfg.mode)
      cccrc_pkg::MODE_CRC8: begin
        sh   = 5'd24;
        mask = 32'h0000_00ff;
      end
      cccrc_pkg::MODE_CRC16: begin
        sh   = 5'd16;
        mask = 32'h0000_ffff;
      end
      cccrc_pkg::MODE_CRC32: begin
        sh   = 5'd0;
        mask = 32'hffff_ffff;
      end
      default: begin
        is_crc = 1'b0;
        sh     = 5'd0;
        mask   = 32'hffff_ffff;
      end
    endcase
  end

  // range start value
  always_comb begin
    init_m = cfg.seed_word & mask;
    poly_m = cfg.poly_word & mask;
    if (!is_crc) begin
      start_val = '0;
    end else if (cfg.crc_reflect) begin
      start_val = rev32(init_m) >> sh;
    end else begin
      start_val = init_m;
    end
    acc0  = st.range_open ? st.acc : start_val;
    held0 = st.range_open ? st.held_byte : 8'd0;
    pend0 = st.range_open ? st.byte_pending : 1'b0;
  end

  // byte-wide crc, msb-first on a left-aligned register or lsb-first
  always_comb begin
    p_al   = poly_m << sh;
    c_norm = (acc0 << sh) ^ {data_byte, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c_norm = c_norm[31] ? ((c_norm << 1) ^ p_al) : (c_norm << 1);
    end
    rp     = rev32(poly_m) >> sh;
    c_refl = (acc0 ^ {24'd0, data_byte}) & mask;
    for (int i = 0; i < 8; i++) begin
      c_refl = c_refl[0] ? ((c_refl >> 1) ^ rp) : (c_refl >> 1);
    end
    crc_n = cfg.crc_reflect ? c_refl : (c_norm >> sh);
  end

  // per-mode accumulate
  always_comb begin
    pair_w = cfg.big_endian ? {held0, data_byte} : {data_byte, held0};
    acc1   = acc0;
    held1  = held0;
    pend1  = pend0;
    case (cfg.mode)
      cccrc_pkg::MODE_SUM16W: begin
        if (pend0) begin
          acc1  = {16'd0, acc0[15:0] + pair_w};
          pend1 = 1'b0;
          held1 = 8'd0;
        end else begin
          held1 = data_byte;
          pend1 = 1'b1;
        end
      end
      cccrc_pkg::MODE_SUM16B: acc1 = {16'd0, acc0[15:0] + {8'd0, data_byte}};
      cccrc_pkg::MODE_CRC8,
      cccrc_pkg::MODE_CRC16,
      cccrc_pkg::MODE_CRC32:  acc1 = crc_n;
      default:                acc1 = {24'd0, acc0[7:0] + data_byte};
    endcase
  end

  // finish on the last byte, an unpaired byte pairs with zero
  always_comb begin
    tail_w   = cfg.big_endian ? {held1, 8'd0} : {8'd0, held1};
    word_sum = pend1 ? (acc1[15:0] + tail_w) : acc1[15:0];
    case (cfg.mode)
      cccrc_pkg::MODE_SUM16W: check_value = {16'd0, word_sum};
      cccrc_pkg::MODE_SUM16B: check_value = {16'd0, acc1[15:0]};
      cccrc_pkg::MODE_CRC8,
      cccrc_pkg::MODE_CRC16,
      cccrc_pkg::MODE_CRC32:  check_value = (acc1 ^ cfg.crc_xor_out) & mask;
      default:                check_value = {24'd0, acc1[7:0]};
    endcase
    if (last_byte) begin
      st_nxt = '0;
    end else begin
      st_nxt.acc          = acc1;
      st_nxt.held_byte    = held1;
      st_nxt.byte_pending = pend1;
      st_nxt.range_open   = 1'b1;
    end
  end

endmodule

// File: sv/configurable_checksum_crc_engine.sv
`timescale 1ns / 1ps
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall  | in_data_byte[7:0], in_last_byte
// out_     | output    | out_valid/out_stall| out_check_value[31:0]
// cfg_     | input     | cfg_we             | cfg_index[2:0], cfg_wdata[31:0]
//
// one byte per cycle sustained while the output is not stalled; a request is
// registered in the input register, then the crc or sum step runs from the
// input register into the running state and the result register, so a
// result is offered once its last byte moves on from the input register.
// reset (rst_n low at a clock edge) clears both stages, the running state
// and the registers to their defaults.
// out_stall holds the result register and, with an item waiting behind it,
// the input register; the input register still fills while the output waits.

module configurable_checksum_crc_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_check_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  cccrc_pkg::cfg_t   cfg_r;
  cccrc_pkg::state_t st_r;
  cccrc_pkg::state_t st_nxt;
  logic              v1_r;
  logic [7:0]        data_r;
  logic              last_r;
  logic              out_valid_r;
  logic [31:0]       out_value_r;
  logic [31:0]       result;
  logic              adv;
  logic              in_acc;

  // handshake
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = v1_r && !adv;
  assign in_acc   = in_valid && !in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode        <= cccrc_pkg::MODE_SUM8;
      cfg_r.big_endian  <= 1'b0;
      cfg_r.poly_word   <= cccrc_pkg::POLY_RESET;
      cfg_r.seed_word   <= '0;
      cfg_r.crc_xor_out <= '0;
      cfg_r.crc_reflect <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        cccrc_pkg::REG_MODE:       cfg_r.mode <= cccrc_pkg::mode_t'(cfg_wdata[2:0]);
        cccrc_pkg::REG_BIG_ENDIAN: cfg_r.big_endian <= cfg_wdata[0];
        cccrc_pkg::REG_POLY:       cfg_r.poly_word <= cfg_wdata;
        cccrc_pkg::REG_SEED:       cfg_r.seed_word <= cfg_wdata;
        cccrc_pkg::REG_CRC_XOR:    cfg_r.crc_xor_out <= cfg_wdata;
        cccrc_pkg::REG_CRC_REFL:   cfg_r.crc_reflect <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (in_acc) begin
      v1_r <= 1'b1;
    end else if (adv) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      data_r <= in_data_byte;
      last_r <= in_last_byte;
    end
  end

  cccrc_datapath u_dp (
    .cfg         (cfg_r),
    .st          (st_r),
    .data_byte   (data_r),
    .last_byte   (last_r),
    .st_nxt      (st_nxt),
    .check_value (result)
  );

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (v1_r && adv) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v1_r && last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v1_r && last_r) begin
      out_value_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_check_value = out_value_r;

endmodule

// File: sv/cccrc_checker.sv
`timescale 1ns / 1ps

module cccrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_last_byte,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_check_value
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_check_value))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

  // a fresh result follows the taking of a last byte
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_last_byte, 2))
    else $error("result without a last byte");

endmodule

bind configurable_checksum_crc_engine cccrc_checker u_cccrc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_last_byte    (in_last_byte),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_check_value (out_check_value)
);

// File: verif/checksum_checker.sv
`timescale 1ns / 1ps

module checksum_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_check_value,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  output int          mismatches,
  output int          outstanding
);

  // register copy, follows every write seen on the cfg port
  logic [2:0]  cur_mode;
  logic        cur_big_endian;
  logic [31:0] cur_poly;
  logic [31:0] cur_init;
  logic [31:0] cur_xor;
  logic        cur_reflect;

  // running check state
  logic [31:0] run_acc;
  logic [7:0]  pair_hold;
  logic        pair_waiting;
  logic        range_live;

  // check values still owed by the block, oldest first
  logic [31:0] expected_checks[$];

  function automatic bit is_crc_mode();
    return cur_mode == cccrc_pkg::MODE_CRC8 || cur_mode == cccrc_pkg::MODE_CRC16 ||
           cur_mode == cccrc_pkg::MODE_CRC32;
  endfunction

  function automatic int crc_bits();
    if (cur_mode == cccrc_pkg::MODE_CRC8) return 8;
    if (cur_mode == cccrc_pkg::MODE_CRC16) return 16;
    return 32;
  endfunction

  function automatic logic [31:0] width_ones(int w);
    if (w == 8) return 32'h0000_00ff;
    if (w == 16) return 32'h0000_ffff;
    return 32'hffff_ffff;
  endfunction

  // reverse the low w bits
  function automatic logic [31:0] bit_mirror(logic [31:0] v, int w);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < w; i++) r = {r[30:0], v[i]};
    return r;
  endfunction

  // accumulator value at the first byte of a range
  function automatic logic [31:0] range_seed();
    logic [31:0] v;
    if (!is_crc_mode()) return '0;
    v = cur_init & width_ones(crc_bits());
    return cur_reflect ? bit_mirror(v, crc_bits()) : v;
  endfunction

  // one byte through the crc, bitwise
  function automatic logic [31:0] crc_update(logic [31:0] crc_in, logic [7:0] d);
    int          w;
    logic [31:0] m;
    logic [31:0] p;
    logic [31:0] rp;
    logic [31:0] crc;
    w = crc_bits();
    m = width_ones(w);
    p = cur_poly & m;
    crc = crc_in;
    if (cur_reflect) begin
      rp = bit_mirror(p, w);
      crc = (crc ^ {24'd0, d}) & m;
      for (int i = 0; i < 8; i++) crc = crc[0] ? ((crc >> 1) ^ rp) : (crc >> 1);
    end else begin
      crc = (crc ^ ({24'd0, d} << (w - 8))) & m;
      for (int i = 0; i < 8; i++)
        crc = crc[w-1] ? (((crc << 1) ^ p) & m) : ((crc << 1) & m);
    end
    return crc & m;
  endfunction

  function automatic logic [31:0] word_of_pair(logic [7:0] first, logic [7:0] second);
    return cur_big_endian ? {16'd0, first, second} : {16'd0, second, first};
  endfunction

  // fold one accepted request into the state, queue a check value on the last byte
  task automatic absorb_byte(input logic [7:0] d, input logic last);
    logic [31:0] check;
    if (!range_live) begin
      run_acc = range_seed();
      pair_hold = '0;
      pair_waiting = 1'b0;
      range_live = 1'b1;
    end
    if (cur_mode == cccrc_pkg::MODE_SUM16W) begin
      if (pair_waiting) begin
        run_acc = (run_acc + word_of_pair(pair_hold, d)) & 32'h0000_ffff;
        pair_waiting = 1'b0;
        pair_hold = '0;
      end else begin
        pair_hold = d;
        pair_waiting = 1'b1;
      end
    end else if (cur_mode == cccrc_pkg::MODE_SUM16B) begin
      run_acc = (run_acc + {24'd0, d}) & 32'h0000_ffff;
    end else if (is_crc_mode()) begin
      run_acc = crc_update(run_acc, d);
    end else begin
      run_acc = (run_acc + {24'd0, d}) & 32'h0000_00ff;
    end
    if (last) begin
      if (cur_mode == cccrc_pkg::MODE_SUM16W) begin
        // odd byte count: the lone byte pairs with zero
        if (pair_waiting) run_acc = (run_acc + word_of_pair(pair_hold, 8'd0)) & 32'h0000_ffff;
        check = run_acc & 32'h0000_ffff;
      end else if (cur_mode == cccrc_pkg::MODE_SUM16B) begin
        check = run_acc & 32'h0000_ffff;
      end else if (is_crc_mode()) begin
        check = (run_acc ^ cur_xor) & width_ones(crc_bits());
      end else begin
        check = run_acc & 32'h0000_00ff;
      end
      expected_checks.push_back(check);
      run_acc = '0;
      pair_hold = '0;
      pair_waiting = 1'b0;
      range_live = 1'b0;
    end
  endtask

  task automatic compare_check(input logic [31:0] got);
    logic [31:0] want;
    if (expected_checks.size() == 0) begin
      if (mismatches < 10) $display("unexpected check value %08h at %0t", got, $realtime);
      mismatches++;
    end else begin
      want = expected_checks.pop_front();
      if (got !== want) begin
        if (mismatches < 10)
          $display("check value mismatch at %0t: expected %08h, got %08h", $realtime, want, got);
        mismatches++;
      end
    end
  endtask

  // sample both channels and the cfg port at each edge
  always @(posedge clk) begin
    if (!rst_n) begin
      cur_mode = cccrc_pkg::MODE_SUM8;
      cur_big_endian = 1'b0;
      cur_poly = cccrc_pkg::POLY_RESET;
      cur_init = '0;
      cur_xor = '0;
      cur_reflect = 1'b0;
      run_acc = '0;
      pair_hold = '0;
      pair_waiting = 1'b0;
      range_live = 1'b0;
      expected_checks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cccrc_pkg::REG_MODE:       cur_mode = cfg_wdata[2:0];
          cccrc_pkg::REG_BIG_ENDIAN: cur_big_endian = cfg_wdata[0];
          cccrc_pkg::REG_POLY:       cur_poly = cfg_wdata;
          cccrc_pkg::REG_SEED:       cur_init = cfg_wdata;
          cccrc_pkg::REG_CRC_XOR:    cur_xor = cfg_wdata;
          cccrc_pkg::REG_CRC_REFL:   cur_reflect = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_byte(in_data_byte, in_last_byte);
      if (out_valid && !out_stall) compare_check(out_check_value);
    end
    outstanding = expected_checks.size();
  end

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 8;
  localparam int ITEM_GOAL      = 550;
  localparam int BURST_ITEMS    = 24;

  // mode codes with no mode of their own, they fall back to the byte sum
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_check_value;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_wdata;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_requests = 0;
  int holds_started = 0;
  bit tx_gaps_on = 1'b1;

  always #5 clk = ~clk;

  configurable_checksum_crc_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_check_value (out_check_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  checksum_checker value_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_check_value (out_check_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding)
  );

  // no request moved for too long
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: free stretches, short stalls, a few long ones, and requested hold-offs
  initial begin
    int pick;
    int len;
    forever begin
      if (holds_started < hold_requests) begin
        holds_started++;
        out_stall <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 30);
        end else if (pick < 9) begin
          out_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          len = $urandom_range(10, 40);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  function automatic int idle_gap();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h0000_0001;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [2:0] pick_mode();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 18) return 3'(pick % 6);
    return (pick == 18) ? MODE_SPARE_LO : MODE_SPARE_HI;
  endfunction

  function automatic int range_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(9, 40);
    return $urandom_range(1, 8);
  endfunction

  // offer one byte, return at the edge that takes it
  task automatic send_byte(input logic [7:0] d, input logic last);
    int gap;
    gap = tx_gaps_on ? idle_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_range(input int len);
    for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
  endtask

  // stop sending until every owed check value is out, then let the pipe empty
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    cfg_index <= idx;
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_config(input logic [2:0] m, input logic be, input logic [31:0] poly,
                              input logic [31:0] init, input logic [31:0] xo,
                              input logic refl);
    drain_results();
    write_reg(cccrc_pkg::REG_MODE, {29'd0, m});
    write_reg(cccrc_pkg::REG_BIG_ENDIAN, {31'd0, be});
    write_reg(cccrc_pkg::REG_POLY, poly);
    write_reg(cccrc_pkg::REG_SEED, init);
    write_reg(cccrc_pkg::REG_CRC_XOR, xo);
    write_reg(cccrc_pkg::REG_CRC_REFL, {31'd0, refl});
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data_byte <= '0;
    in_last_byte <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cccrc_pkg::REG_MODE;
    cfg_wdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // registers at their reset values: byte sum that wraps
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b1);
    // crc8 on the reset polynomial
    drain_results();
    write_reg(cccrc_pkg::REG_MODE, {29'd0, cccrc_pkg::MODE_CRC8});
    send_byte(8'h31, 1'b1);

    // word sum with an odd count and an even one, both byte orders, then the byte-wise 16-bit sum
    apply_config(cccrc_pkg::MODE_SUM16W, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hab, 1'b1);
    apply_config(cccrc_pkg::MODE_SUM16W, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    apply_config(cccrc_pkg::MODE_SUM16B, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'hff, 1'b1);

    // crc widths, reflection, extremes, poly bits above the width
    apply_config(cccrc_pkg::MODE_CRC16, 1'b0, 32'h0000_8005, 32'hffff_ffff, 32'h0, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    apply_config(cccrc_pkg::MODE_CRC32, 1'b0, 32'h04c1_1db7, 32'hffff_ffff, 32'hffff_ffff,
                 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    apply_config(cccrc_pkg::MODE_CRC32, 1'b1, 32'hffff_ffff, 32'h0, 32'h0, 1'b0);
    send_byte(8'h80, 1'b1);
    apply_config(cccrc_pkg::MODE_CRC8, 1'b0, 32'hdead_be07, 32'h1234_56a5, 32'hffff_ff0f,
                 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'hc3, 1'b1);

    // unused mode codes
    apply_config(MODE_SPARE_LO, 1'b1, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'hf0, 1'b0);
    send_byte(8'h20, 1'b1);
    apply_config(MODE_SPARE_HI, 1'b0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
    send_byte(8'h7f, 1'b1);

    // word sum left mid-pair: the held byte is dropped
    apply_config(cccrc_pkg::MODE_SUM16W, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'h5a, 1'b0);
    apply_config(cccrc_pkg::MODE_SUM16B, 1'b0, 32'h0, 32'h0, 32'h0, 1'b0);
    send_byte(8'h01, 1'b1);

    // receiver holds off while one-byte ranges keep coming
    apply_config(cccrc_pkg::MODE_CRC32, 1'b0, 32'h04c1_1db7, 32'hffff_ffff, 32'hffff_ffff,
                 1'b1);
    tx_gaps_on = 1'b0;
    hold_requests++;
    while (holds_started < hold_requests) @(negedge clk);
    @(posedge clk);
    repeat (BURST_ITEMS) send_byte(8'($urandom_range(0, 255)), 1'b1);

    // random settings, a few ranges each
    while (items_sent < ITEM_GOAL) begin
      apply_config(pick_mode(), 1'($urandom_range(0, 1)), pick_word(), pick_word(),
                   pick_word(), 1'($urandom_range(0, 1)));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 6)) send_range(range_len());
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
sv/cccrc_pkg.sv
sv/cccrc_datapath.sv
sv/configurable_checksum_crc_engine.sv
sv/cccrc_checker.sv
verif/checksum_checker.sv
verif/testbench.sv
